/* rtl/qoa_pkg.sv */
`default_nettype none

package qoa_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int COMP_W        = 16;
    // multiplicand width: rotation matrix entries need 33 signed bits
    localparam int MA_W          = 34;
    // divisor width: |q|^2 of four 16-bit components
    localparam int DEN_W         = 33;
    // dividend width: doubled rotation sums plus rounding term
    localparam int DIV_NW        = 53;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_COMPOSE = 2'd1,
        OP_CONJ    = 2'd2,
        OP_ROTATE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HAM,
        ST_LEN,
        ST_SQRT,
        ST_NDIV,
        ST_NSQ,
        ST_COEF,
        ST_TMUL,
        ST_RDIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic clr;
        logic neg;
    } mac_ctl_t;

    typedef struct packed {
        logic [1:0] a_idx;
        logic [1:0] b_idx;
        logic       neg;
    } term_t;

    // Hamilton product: component k takes w[j] * q[k ^ j]; sign mask per k
    function automatic logic ham_neg(logic [1:0] k, logic [1:0] j);
        logic [3:0] mask;
        unique case (k)
            2'd0:    mask = 4'b1110;
            2'd1:    mask = 4'b1000;
            2'd2:    mask = 4'b0010;
            default: mask = 4'b0100;
        endcase
        return mask[j];
    endfunction

    // Rotation matrix entry (row i, column j) as two products of state
    // components (0 s, 1 x, 2 y, 3 z); t selects the product.
    function automatic term_t coef_term(logic [1:0] i, logic [1:0] j, logic t);
        term_t r;
        unique case ({i, j, t})
            5'b00_00_0: r = '{2'd2, 2'd2, 1'b1};
            5'b00_00_1: r = '{2'd3, 2'd3, 1'b1};
            5'b00_01_0: r = '{2'd1, 2'd2, 1'b0};
            5'b00_01_1: r = '{2'd3, 2'd0, 1'b1};
            5'b00_10_0: r = '{2'd1, 2'd3, 1'b0};
            5'b00_10_1: r = '{2'd2, 2'd0, 1'b0};
            5'b01_00_0: r = '{2'd1, 2'd2, 1'b0};
            5'b01_00_1: r = '{2'd3, 2'd0, 1'b0};
            5'b01_01_0: r = '{2'd1, 2'd1, 1'b1};
            5'b01_01_1: r = '{2'd3, 2'd3, 1'b1};
            5'b01_10_0: r = '{2'd2, 2'd3, 1'b0};
            5'b01_10_1: r = '{2'd1, 2'd0, 1'b1};
            5'b10_00_0: r = '{2'd1, 2'd3, 1'b0};
            5'b10_00_1: r = '{2'd2, 2'd0, 1'b1};
            5'b10_01_0: r = '{2'd2, 2'd3, 1'b0};
            5'b10_01_1: r = '{2'd1, 2'd0, 1'b0};
            5'b10_10_0: r = '{2'd1, 2'd1, 1'b1};
            5'b10_10_1: r = '{2'd2, 2'd2, 1'b1};
            default:    r = '{2'd0, 2'd0, 1'b0};
        endcase
        return r;
    endfunction

    function automatic logic signed [COMP_W-1:0] sat16(logic signed [34:0] v);
        logic signed [COMP_W-1:0] r;
        if (v > 35'sd32767) begin
            r = 16'sh7fff;
        end
        else if (v < -35'sd32768) begin
            r = 16'sh8000;
        end
        else begin
            r = v[COMP_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/qoa_if.sv */
`default_nettype none

interface qoa_cmd_if import qoa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    op_t                      operation;
    logic signed [COMP_W-1:0] in_s;
    logic signed [COMP_W-1:0] in_x;
    logic signed [COMP_W-1:0] in_y;
    logic signed [COMP_W-1:0] in_z;

    modport source (output valid, operation, in_s, in_x, in_y, in_z, input ready);
    modport sink   (input valid, operation, in_s, in_x, in_y, in_z, output ready);
endinterface

interface qoa_rsp_if import qoa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] out_s;
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic                     zero_length;

    modport source (output valid, out_s, out_x, out_y, out_z, zero_length, input ready);
    modport sink   (input valid, out_s, out_x, out_y, out_z, zero_length, output ready);
endinterface

`default_nettype wire

/* rtl/quaternion_orientation_accumulator.sv */
`default_nettype none

// Quaternion orientation accumulator. Holds one orientation (s, x, y, z) in
// signed fixed point with FRAC_BITS fraction bits (Q2.14 by default), cleared
// to zero by reset. Each cmd item carries an operation: load sets the state,
// compose multiplies the state on the right by the input quaternion (a zero
// state counts as identity) and renormalizes, conjugate negates the vector
// part, and rotate returns the input vector turned by the state's rotation
// matrix scaled by 1/|q|^2. Each item yields exactly one rsp item with the
// new state (or the rotated vector, out_s zero) and zero_length set when
// compose or rotate met a zero-length quaternion. All arithmetic goes through
// one bit-serial multiply-accumulate unit, a bit-serial square root and a
// bit-serial divider; load and conjugate use none of them. The multiplier
// walks one bit of its B = max(16, 35 - FRAC_BITS) bit operand per cycle
// (21 bits at Q2.14) and sets how long compose and rotate take; the divider
// yields a Q = max(20, FRAC_BITS + 2) bit quotient (20 bits at Q2.14). A
// new cmd item is taken as soon as the previous result sits in the output
// register.
module quaternion_orientation_accumulator import qoa_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    qoa_cmd_if.sink   cmd,
    qoa_rsp_if.source rsp
);

    localparam int H_W    = 35 - FRAC_BITS;
    localparam int B_W    = (H_W > COMP_W) ? H_W : COMP_W;
    localparam int ACC_W  = MA_W + B_W + 2;
    localparam int SQ_W   = 2 * H_W + 2;
    localparam int R_W    = SQ_W / 2;
    localparam int DIV_QW = (FRAC_BITS + 2 > 20) ? FRAC_BITS + 2 : 20;

    localparam logic [ACC_W-1:0] HALF_ONE = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [COMP_W-1:0] ID_S =
        (FRAC_BITS >= COMP_W - 1) ? 16'sh7fff : COMP_W'(2 ** FRAC_BITS);

    // control
    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   issued_reg, issued_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] j_reg, j_next;
    logic       t_reg, t_next;
    logic       ovalid_reg, ovalid_next;

    // datapath
    logic signed [COMP_W-1:0] orient_reg[4], orient_next[4];
    logic signed [COMP_W-1:0] w_reg[4], w_next[4];
    logic signed [COMP_W-1:0] q_reg[4], q_next[4];
    logic signed [COMP_W-1:0] res_reg[4], res_next[4];
    logic signed [COMP_W-1:0] obuf_reg[4], obuf_next[4];
    logic signed [H_W-1:0]    h_reg[4], h_next[4];
    logic                     flag_reg, flag_next;
    logic                     ozl_reg, ozl_next;
    logic [R_W-1:0]           len_reg, len_next;
    logic [DEN_W-1:0]         n_reg, n_next;
    logic signed [MA_W-1:0]   coef_reg, coef_next;
    logic signed [ACC_W-1:0]  tacc_reg, tacc_next;

    // unit hookups
    mac_ctl_t                mac_ctl;
    logic signed [MA_W-1:0]  mac_a;
    logic signed [B_W-1:0]   mac_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_busy;
    logic                    mac_done;
    logic                    sqrt_start;
    logic [R_W-1:0]          sqrt_root;
    logic                    sqrt_done;
    logic                    div_start;
    logic [DIV_NW-1:0]       div_num;
    logic [DEN_W-1:0]        div_den;
    logic [DIV_QW-1:0]       div_quot;
    logic                    div_done;

    // helpers
    logic [ACC_W-1:0]        p_mag;
    logic [ACC_W-1:0]        hr_mag;
    logic signed [H_W-1:0]   h_round;
    logic signed [H_W-1:0]   hk;
    logic [H_W-1:0]          hk_mag;
    logic signed [ACC_W-1:0] t_twice;
    logic [ACC_W-1:0]        t_mag;
    logic signed [34:0]      qx;
    logic signed [34:0]      q_signed;
    logic signed [34:0]      v_sum;
    logic signed [COMP_W-1:0] v_k;
    logic                    state_zero;
    term_t                   term;

    qoa_mac #(.B_W(B_W), .ACC_W(ACC_W)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc),
        .busy  (mac_busy),
        .done  (mac_done)
    );

    qoa_sqrt #(.SQ_W(SQ_W)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (mac_acc[SQ_W-1:0]),
        .root  (sqrt_root),
        .done  (sqrt_done)
    );

    qoa_div #(.QW(DIV_QW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    // round a Hamilton sum to h = p / ONE, half away from zero
    assign p_mag   = mac_acc[ACC_W-1] ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
    assign hr_mag  = (p_mag + HALF_ONE) >> FRAC_BITS;
    assign h_round = mac_acc[ACC_W-1] ? -H_W'(hr_mag) : H_W'(hr_mag);

    assign hk      = h_reg[k_reg];
    assign hk_mag  = hk[H_W-1] ? H_W'(-hk) : H_W'(hk);

    assign t_twice = tacc_reg <<< 1;
    assign t_mag   = t_twice[ACC_W-1] ? ACC_W'(-t_twice) : ACC_W'(t_twice);

    assign qx      = 35'(div_quot);
    assign v_k     = q_reg[k_reg + 2'd1];
    assign v_sum   = 35'(v_k) + (tacc_reg[ACC_W-1] ? -qx : qx);
    assign q_signed = hk[H_W-1] ? -qx : qx;

    assign state_zero = (orient_reg[0] == '0) && (orient_reg[1] == '0)
                     && (orient_reg[2] == '0) && (orient_reg[3] == '0);

    assign term = coef_term(k_reg, j_reg, t_reg);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        issued_next = issued_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        t_next      = t_reg;
        ovalid_next = ovalid_reg;
        orient_next = orient_reg;
        w_next      = w_reg;
        q_next      = q_reg;
        res_next    = res_reg;
        obuf_next   = obuf_reg;
        h_next      = h_reg;
        flag_next   = flag_reg;
        ozl_next    = ozl_reg;
        len_next    = len_reg;
        n_next      = n_reg;
        coef_next   = coef_reg;
        tacc_next   = tacc_reg;
        mac_ctl     = '0;
        mac_a       = '0;
        mac_b       = '0;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        cmd.ready   = 1'b0;

        // drop the result once taken
        if (rsp.valid && rsp.ready) begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid) begin
                    op_next     = cmd.operation;
                    q_next[0]   = cmd.in_s;
                    q_next[1]   = cmd.in_x;
                    q_next[2]   = cmd.in_y;
                    q_next[3]   = cmd.in_z;
                    issued_next = 1'b0;
                    k_next      = '0;
                    j_next      = '0;
                    t_next      = 1'b0;
                    flag_next   = 1'b0;
                    unique case (cmd.operation)
                        OP_LOAD:
                        begin
                            orient_next[0] = cmd.in_s;
                            orient_next[1] = cmd.in_x;
                            orient_next[2] = cmd.in_y;
                            orient_next[3] = cmd.in_z;
                            res_next       = orient_next;
                            state_next     = ST_FINISH;
                        end
                        OP_CONJ:
                        begin
                            for (int i = 1; i < 4; i++) begin
                                orient_next[i] = sat16(-35'(orient_reg[i]));
                            end
                            res_next   = orient_next;
                            state_next = ST_FINISH;
                        end
                        OP_COMPOSE:
                        begin
                            // zero state stands in as identity
                            w_next = orient_reg;
                            if (state_zero) begin
                                w_next[0] = ID_S;
                            end
                            state_next = ST_HAM;
                        end
                        default:
                        begin
                            w_next     = orient_reg;
                            state_next = ST_NSQ;
                        end
                    endcase
                end
            end

            ST_HAM:
            begin
                mac_a       = MA_W'(w_reg[j_reg]);
                mac_b       = B_W'(q_reg[k_reg ^ j_reg]);
                mac_ctl.neg = ham_neg(k_reg, j_reg);
                mac_ctl.clr = (j_reg == 2'd0);
                mac_ctl.start = !issued_reg;
                if (!issued_reg) begin
                    issued_next = 1'b1;
                end
                if (mac_done) begin
                    issued_next = 1'b0;
                    j_next      = j_reg + 2'd1;
                    if (j_reg == 2'd3) begin
                        h_next[k_reg] = h_round;
                        k_next        = k_reg + 2'd1;
                        if (k_reg == 2'd3) begin
                            state_next = ST_LEN;
                        end
                    end
                end
            end

            ST_LEN:
            begin
                mac_a       = MA_W'(h_reg[j_reg]);
                mac_b       = B_W'(h_reg[j_reg]);
                mac_ctl.clr = (j_reg == 2'd0);
                mac_ctl.start = !issued_reg;
                if (!issued_reg) begin
                    issued_next = 1'b1;
                end
                if (mac_done) begin
                    issued_next = 1'b0;
                    j_next      = j_reg + 2'd1;
                    if (j_reg == 2'd3) begin
                        if (mac_acc == '0) begin
                            // degenerate product: hold the old state
                            flag_next  = 1'b1;
                            res_next   = orient_reg;
                            state_next = ST_FINISH;
                        end
                        else begin
                            state_next = ST_SQRT;
                        end
                    end
                end
            end

            ST_SQRT:
            begin
                sqrt_start = !issued_reg;
                if (!issued_reg) begin
                    issued_next = 1'b1;
                end
                if (sqrt_done) begin
                    issued_next = 1'b0;
                    len_next    = sqrt_root;
                    k_next      = '0;
                    state_next  = ST_NDIV;
                end
            end

            ST_NDIV:
            begin
                div_num   = (DIV_NW'(hk_mag) << FRAC_BITS) + DIV_NW'(len_reg >> 1);
                div_den   = DEN_W'(len_reg);
                div_start = !issued_reg;
                if (!issued_reg) begin
                    issued_next = 1'b1;
                end
                if (div_done) begin
                    issued_next     = 1'b0;
                    res_next[k_reg] = sat16(q_signed);
                    k_next          = k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        orient_next = res_next;
                        state_next  = ST_FINISH;
                    end
                end
            end

            ST_NSQ:
            begin
                mac_a       = MA_W'(w_reg[j_reg]);
                mac_b       = B_W'(w_reg[j_reg]);
                mac_ctl.clr = (j_reg == 2'd0);
                mac_ctl.start = !issued_reg;
                if (!issued_reg) begin
                    issued_next = 1'b1;
                end
                if (mac_done) begin
                    issued_next = 1'b0;
                    j_next      = j_reg + 2'd1;
                    if (j_reg == 2'd3) begin
                        if (mac_acc == '0) begin
                            // zero state: pass the vector through
                            flag_next  = 1'b1;
                            res_next   = q_reg;
                            res_next[0] = '0;
                            state_next = ST_FINISH;
                        end
                        else begin
                            n_next     = mac_acc[DEN_W-1:0];
                            k_next     = '0;
                            t_next     = 1'b0;
                            state_next = ST_COEF;
                        end
                    end
                end
            end

            ST_COEF:
            begin
                mac_a       = MA_W'(w_reg[term.a_idx]);
                mac_b       = B_W'(w_reg[term.b_idx]);
                mac_ctl.neg = term.neg;
                mac_ctl.clr = !t_reg;
                mac_ctl.start = !issued_reg;
                if (!issued_reg) begin
                    issued_next = 1'b1;
                end
                if (mac_done) begin
                    issued_next = 1'b0;
                    t_next      = !t_reg;
                    if (t_reg) begin
                        coef_next  = mac_acc[MA_W-1:0];
                        state_next = ST_TMUL;
                    end
                end
            end

            ST_TMUL:
            begin
                mac_a       = coef_reg;
                mac_b       = B_W'(q_reg[j_reg + 2'd1]);
                mac_ctl.clr = 1'b1;
                mac_ctl.start = !issued_reg;
                if (!issued_reg) begin
                    issued_next = 1'b1;
                end
                if (mac_done) begin
                    issued_next = 1'b0;
                    tacc_next   = ((j_reg == 2'd0) ? '0 : tacc_reg) + mac_acc;
                    if (j_reg == 2'd2) begin
                        j_next     = '0;
                        state_next = ST_RDIV;
                    end
                    else begin
                        j_next     = j_reg + 2'd1;
                        state_next = ST_COEF;
                    end
                end
            end

            ST_RDIV:
            begin
                div_num   = DIV_NW'(t_mag) + DIV_NW'(n_reg >> 1);
                div_den   = n_reg;
                div_start = !issued_reg;
                if (!issued_reg) begin
                    issued_next = 1'b1;
                end
                if (div_done) begin
                    issued_next            = 1'b0;
                    res_next[0]            = '0;
                    res_next[k_reg + 2'd1] = sat16(v_sum);
                    if (k_reg == 2'd2) begin
                        state_next = ST_FINISH;
                    end
                    else begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_COEF;
                    end
                end
            end

            ST_FINISH:
            begin
                // hand over once the output register is free
                if (!ovalid_reg || rsp.ready) begin
                    ovalid_next = 1'b1;
                    obuf_next   = res_reg;
                    ozl_next    = flag_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            k_reg      <= '0;
            j_reg      <= '0;
            t_reg      <= 1'b0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                orient_reg[i] <= '0;
            end
        end
        else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            t_reg      <= t_next;
            ovalid_reg <= ovalid_next;
            orient_reg <= orient_next;
        end
    end

    always_ff @(posedge clk) begin
        op_reg   <= op_next;
        w_reg    <= w_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
        obuf_reg <= obuf_next;
        h_reg    <= h_next;
        flag_reg <= flag_next;
        ozl_reg  <= ozl_next;
        len_reg  <= len_next;
        n_reg    <= n_next;
        coef_reg <= coef_next;
        tacc_reg <= tacc_next;
    end

    assign rsp.valid       = ovalid_reg;
    assign rsp.out_s       = obuf_reg[0];
    assign rsp.out_x       = obuf_reg[1];
    assign rsp.out_y       = obuf_reg[2];
    assign rsp.out_z       = obuf_reg[3];
    assign rsp.zero_length = ozl_reg;

    // never restart the multiplier mid-product
    a_mac_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctl.start |-> !mac_busy)
        else $error("multiplier started while busy");

    // an accepted item always leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item left block idle");

    // only compose and rotate can flag a zero length
    a_flag_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && flag_reg)
            |-> (op_reg == OP_COMPOSE || op_reg == OP_ROTATE))
        else $error("zero_length raised by load or conjugate");

    // rotate results carry a zero scalar
    a_rotate_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && op_reg == OP_ROTATE) |-> (res_reg[0] == '0))
        else $error("rotate result with nonzero scalar");

endmodule

`default_nettype wire

/* rtl/qoa_mac.sv */
`default_nettype none

// Shift-add multiply-accumulate, one multiplier bit per cycle.
module qoa_mac import qoa_pkg::*; #(
    parameter int B_W   = 21,
    parameter int ACC_W = MA_W + 21 + 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctl_t                ctl,
    input  logic signed [MA_W-1:0]  a,
    input  logic signed [B_W-1:0]   b,
    output logic signed [ACC_W-1:0] acc,
    output logic                    busy,
    output logic                    done
);

    localparam int CNT_W = $clog2(B_W);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] a_reg;
    logic        [B_W-1:0]   b_reg;
    logic        [CNT_W-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic                    neg_reg;

    logic                    last;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] acc_step;

    // top multiplier bit carries negative weight
    assign last     = (cnt_reg == CNT_W'(B_W - 1));
    assign addend   = (neg_reg ^ last) ? -a_reg : a_reg;
    assign acc_step = b_reg[0] ? acc_reg + addend : acc_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= busy_reg && last;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.start) begin
            acc_reg <= ctl.clr ? '0 : acc_reg;
            a_reg   <= ACC_W'(a);
            b_reg   <= b;
            neg_reg <= ctl.neg;
        end
        else if (busy_reg) begin
            acc_reg <= acc_step;
            a_reg   <= a_reg <<< 1;
            b_reg   <= b_reg >> 1;
        end
    end

    assign acc  = acc_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/qoa_sqrt.sv */
`default_nettype none

// Integer square root, one result bit per cycle.
module qoa_sqrt import qoa_pkg::*; #(
    parameter int SQ_W = 44
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SQ_W-1:0]       value,
    output logic [SQ_W/2-1:0]     root,
    output logic                  done
);

    localparam int R_W   = SQ_W / 2;
    localparam int CNT_W = $clog2(R_W);

    logic [SQ_W-1:0]  v_reg;
    logic [R_W:0]     rem_reg;
    logic [R_W-1:0]   root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [R_W+2:0]   rem_sh;
    logic [R_W+2:0]   trial;
    logic [R_W+2:0]   diff;
    logic             ge;
    logic             last;

    assign rem_sh = {rem_reg, v_reg[SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);
    assign last   = (cnt_reg == CNT_W'(R_W - 1));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            v_reg    <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg) begin
            v_reg    <= v_reg << 2;
            rem_reg  <= ge ? diff[R_W:0] : rem_sh[R_W:0];
            root_reg <= {root_reg[R_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/qoa_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle; num < den * 2^QW.
module qoa_div import qoa_pkg::*; #(
    parameter int QW = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DEN_W-1:0]  den,
    output logic [QW-1:0]     quot,
    output logic              done
);

    localparam int CNT_W = $clog2(QW);

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QW-1:0]     lo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_NW-1:0] num_hi;
    logic [DEN_W:0]    sh;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic              last;

    assign num_hi = num >> QW;
    assign sh     = {rem_reg, lo_reg[QW-1]};
    assign diff   = sh - {1'b0, den_reg};
    assign ge     = (sh >= {1'b0, den_reg});
    assign last   = (cnt_reg == CNT_W'(QW - 1));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // dividend low bits shift out at the top, quotient bits enter below
    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= num_hi[DEN_W-1:0];
            den_reg <= den;
            lo_reg  <= num[QW-1:0];
        end
        else if (busy_reg) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
            lo_reg  <= {lo_reg[QW-2:0], ge};
        end
    end

    assign quot = lo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* test/tb_quaternion_orientation_accumulator.sv */
`timescale 1ns / 1ps

module tb_quaternion_orientation_accumulator;
    import qoa_pkg::*;

    localparam int  ONE_Q     = 1 << FRAC_BITS_DEF;
    // hang limit sized for rotate items at Q2.14; leave a wide margin for stalls
    localparam longint CYCLE_LIMIT = 8_000_000;

    typedef struct packed {
        logic signed [15:0] s;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               zl;
    } orient_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qoa_cmd_if cmd_ch ();
    qoa_rsp_if rsp_ch ();

    quaternion_orientation_accumulator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #10 clk = ~clk;

    // Predictor copy of the orientation (s, x, y, z)
    longint      orient [4];
    orient_rsp_t pending_rsp [$];
    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          err_cnt   = 0;
    int          rsp_cnt   = 0;
    int          op_cnt [4];
    int          zl_cnt    = 0;
    longint      cycle_cnt = 0;

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // round to nearest, halves away from zero; den > 0
    function automatic longint div_near(longint num, longint den);
        longint q;
        q = ((num < 0 ? -num : num) + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
            begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // Advance the orientation by one item and return the result it yields
    function automatic orient_rsp_t predict_orient(op_t op, longint qi [4]);
        orient_rsp_t r;
        longint s, x, y, z, n;
        longint p [4];
        longint h [4];
        longint t [3];
        longint len2, len;
        r = '0;
        s = orient[0];
        x = orient[1];
        y = orient[2];
        z = orient[3];
        case (op)
            OP_LOAD:
            begin
                for (int i = 0; i < 4; i++) orient[i] = qi[i];
            end
            OP_COMPOSE:
            begin
                // a cleared state acts as identity
                if (s == 0 && x == 0 && y == 0 && z == 0) s = longint'(clamp16(ONE_Q));
                p[0] = s * qi[0] - x * qi[1] - y * qi[2] - z * qi[3];
                p[1] = s * qi[1] + x * qi[0] + y * qi[3] - z * qi[2];
                p[2] = s * qi[2] - x * qi[3] + y * qi[0] + z * qi[1];
                p[3] = s * qi[3] + x * qi[2] - y * qi[1] + z * qi[0];
                len2 = 0;
                for (int i = 0; i < 4; i++)
                begin
                    h[i] = div_near(p[i], longint'(ONE_Q));
                    len2 += h[i] * h[i];
                end
                if (len2 == 0)
                begin
                    r.zl = 1'b1;
                end
                else
                begin
                    len = floor_sqrt(len2);
                    for (int i = 0; i < 4; i++)
                        orient[i] = longint'(clamp16(div_near(h[i] * ONE_Q, len)));
                end
            end
            OP_CONJ:
            begin
                for (int i = 1; i < 4; i++) orient[i] = longint'(clamp16(-orient[i]));
            end
            default:
            begin
            end
        endcase
        if (op == OP_ROTATE)
        begin
            n = s * s + x * x + y * y + z * z;
            if (n == 0)
            begin
                r.x = qi[1][15:0];
                r.y = qi[2][15:0];
                r.z = qi[3][15:0];
                r.zl = 1'b1;
            end
            else
            begin
                t[0] = -(y * y + z * z) * qi[1] + (x * y - z * s) * qi[2]
                       + (x * z + y * s) * qi[3];
                t[1] = (x * y + z * s) * qi[1] - (x * x + z * z) * qi[2]
                       + (y * z - x * s) * qi[3];
                t[2] = (x * z - y * s) * qi[1] + (y * z + x * s) * qi[2]
                       - (x * x + y * y) * qi[3];
                r.x = clamp16(qi[1] + div_near(2 * t[0], n));
                r.y = clamp16(qi[2] + div_near(2 * t[1], n));
                r.z = clamp16(qi[3] + div_near(2 * t[2], n));
            end
        end
        else
        begin
            r.s = orient[0][15:0];
            r.x = orient[1][15:0];
            r.y = orient[2][15:0];
            r.z = orient[3][15:0];
        end
        return r;
    endfunction

    // Send one item: optional idle gap, then hold valid until accepted
    task automatic send_item(op_t op, int qs, int qx, int qy, int qz);
        longint qi [4];
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.in_s      <= qs[15:0];
        cmd_ch.in_x      <= qx[15:0];
        cmd_ch.in_y      <= qy[15:0];
        cmd_ch.in_z      <= qz[15:0];
        do @(posedge clk); while (!cmd_ch.ready);
        qi[0] = longint'($signed(qs[15:0]));
        qi[1] = longint'($signed(qx[15:0]));
        qi[2] = longint'($signed(qy[15:0]));
        qi[3] = longint'($signed(qz[15:0]));
        pending_rsp.push_back(predict_orient(op, qi));
        op_cnt[op]++;
    endtask

    task automatic drop_valid();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reset-state corners, saturating conjugate, extremes of every field
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(OP_ROTATE, 0, 1234, -32768, 32767);       // rotate on cleared state
        send_item(OP_COMPOSE, 0, 0, 0, 0);                  // zero product, state stays clear
        send_item(OP_COMPOSE, 16384, 0, 0, 0);              // cleared state taken as identity
        send_item(OP_ROTATE, 0, 32767, -32768, 100);
        send_item(OP_LOAD, -32768, -32768, -32768, -32768);
        send_item(OP_CONJ, 0, 0, 0, 0);                     // -32768 negates to 32767
        send_item(OP_ROTATE, -1, 32767, 32767, -32768);
        send_item(OP_COMPOSE, 32767, 32767, 32767, 32767);
        send_item(OP_LOAD, 32767, 32767, 32767, 32767);
        send_item(OP_ROTATE, 32767, -32768, -32768, -32768);
        send_item(OP_COMPOSE, -32768, 0, 0, 0);
        send_item(OP_LOAD, 11585, 11585, 0, 0);             // 90 degrees about x
        send_item(OP_ROTATE, 0, 0, 1000, 0);
        send_item(OP_COMPOSE, 11585, 0, 11585, 0);
        send_item(OP_CONJ, -1, -1, -1, -1);
        send_item(OP_ROTATE, 0, 300, -300, 3000);
        send_item(OP_LOAD, 1, 0, 0, 0);                     // tiny norm
        send_item(OP_COMPOSE, 1, 0, 0, 0);                  // product rounds to zero
        send_item(OP_ROTATE, 0, -32768, 32767, -5);
        send_item(OP_LOAD, 0, 0, 0, 0);
        send_item(OP_ROTATE, 0, -1, -1, -1);
        send_item(OP_CONJ, 0, 0, 0, 0);
        send_item(OP_COMPOSE, 0, 0, 0, 16384);
        drop_valid();
    endtask

    function automatic int unit_comp();
        return $urandom_range(32768) - 16384;
    endfunction

    function automatic int any_comp();
        return $urandom_range(65535) - 32768;
    endfunction

    // Random mix of operations: some components within +-1.0, the rest raw noise
    task automatic test_random(int n_items, int sender_idle, int recv_stall);
        int sel;
        idle_pct  = sender_idle;
        stall_pct = recv_stall;
        for (int k = 0; k < n_items; k++)
        begin
            sel = $urandom_range(99);
            if (sel < 4)
                send_item(OP_LOAD, 0, 0, 0, 0);
            else if (sel < 14)
                send_item(OP_LOAD, any_comp(), any_comp(), any_comp(), any_comp());
            else if (sel < 22)
                send_item(OP_LOAD, unit_comp(), unit_comp(), unit_comp(), unit_comp());
            else if (sel < 52)
                send_item(OP_COMPOSE, unit_comp(), unit_comp(), unit_comp(), unit_comp());
            else if (sel < 57)
                send_item(OP_COMPOSE, any_comp(), any_comp(), any_comp(), any_comp());
            else if (sel < 59)
                send_item(OP_COMPOSE, $urandom_range(2) - 1, 0, 0, $urandom_range(2) - 1);
            else if (sel < 72)
                send_item(OP_CONJ, any_comp(), any_comp(), any_comp(), any_comp());
            else
                send_item(OP_ROTATE, any_comp(), any_comp(), any_comp(), any_comp());
        end
        drop_valid();
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    // Result side stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        orient_rsp_t want;
        orient_rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.out_s, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z,
                    rsp_ch.zero_length};
            rsp_cnt++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result s=%0d x=%0d y=%0d z=%0d zl=%0b", $time,
                         got.s, got.x, got.y, got.z, got.zl);
                err_cnt++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected s=%0d x=%0d y=%0d z=%0d zl=%0b",
                             $time, want.s, want.x, want.y, want.z, want.zl);
                    $display("%0t:          actual   s=%0d x=%0d y=%0d z=%0d zl=%0b",
                             $time, got.s, got.x, got.y, got.z, got.zl);
                    err_cnt++;
                end
                if (want.zl) zl_cnt++;
            end
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_quaternion_orientation_accumulator failed");
            $finish;
        end
    end

    initial
    begin
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = OP_LOAD;
        cmd_ch.in_s      = '0;
        cmd_ch.in_x      = '0;
        cmd_ch.in_y      = '0;
        cmd_ch.in_z      = '0;
        for (int i = 0; i < 4; i++)
        begin
            orient[i] = 0;
            op_cnt[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(360, 0, 0);
        test_random(360, 83, 0);
        test_random(360, 0, 83);
        test_random(360, 6, 6);
        repeat (20) @(posedge clk);

        $display("Covered %0d results: %0d load, %0d compose, %0d conjugate, %0d rotate,",
                 rsp_cnt, op_cnt[OP_LOAD], op_cnt[OP_COMPOSE], op_cnt[OP_CONJ],
                 op_cnt[OP_ROTATE]);
        $display("%0d zero-length cases, under four sender/receiver stall mixes.", zl_cnt);
        if (err_cnt == 0 && pending_rsp.size() == 0)
            $display("tb_quaternion_orientation_accumulator passed");
        else
            $display("tb_quaternion_orientation_accumulator failed");
        $finish;
    end

endmodule
